// File: rtl/core/linear_resampler_with_downmix_macros.svh
// Assertion macros shared by the checker of the resampler.
// No dependencies; every macro samples on clk and is quiet while rst_n is low.
`ifndef LINEAR_RESAMPLER_WITH_DOWNMIX_MACROS_SVH
`define LINEAR_RESAMPLER_WITH_DOWNMIX_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

// File: rtl/core/lrd_pkg.sv
// Shared types, constants and register codes of the resampler.
// No dependencies; imported by every module of the block.
package lrd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_OUTPUTS = 64;
  localparam int RATE_W      = 18;
  localparam int PHASE_W     = 19;
  localparam int EMIT_W      = $clog2(MAX_OUTPUTS + 1);
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int PROD_W      = DIFF_W + PHASE_W;
  // Divider: quotient never reaches 2**QUO_W, so the top bits start as the remainder.
  localparam int QUO_W       = DIFF_W;
  localparam int DVD_W       = QUO_W + RATE_W;
  localparam int QCNT_W      = $clog2(QUO_W + 1);
  // Queue between front and back; depth is a power of two.
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_AW      = 4;
  localparam int REG_IDX_W   = 2;
  localparam logic [REG_IDX_W-1:0] REG_IN_RATE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_RATE    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE = 2'd2;

  localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd48000;
  localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;

  typedef struct packed {
    logic [RATE_W-1:0] in_rate;
    logic [RATE_W-1:0] out_rate;
    logic              stereo_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mono;
    logic                          last;
  } frame_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quot;
    logic [RATE_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1_START,
    ST_K1_WAIT,
    ST_K1_MUL,
    ST_K1_ADD,
    ST_K2_START,
    ST_K2_WAIT,
    ST_PLAN,
    ST_OUT_START,
    ST_OUT_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_FINISH
  } back_state_t;

endpackage

// File: rtl/core/lrd_front.sv
// Front end: accepts input frames and reduces each to one mono sample.
// Depends on lrd_pkg; pushes into lrd_fifo.
module lrd_front (
  input  logic                          stereo_mode,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [47:0]                   in_tdata,  // left_sample[23:0], right_sample[47:24]
  input  logic                          in_tlast,  // last_frame
  input  logic                          fifo_full,
  output logic                          push,
  output lrd_pkg::frame_t               push_data
);
  import lrd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] left;
  logic signed [SAMPLE_BITS-1:0] right;
  logic signed [DIFF_W-1:0]      sum;

  assign left  = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign right = $signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  // Floor of the average is an arithmetic shift of the full-width sum.
  assign sum   = DIFF_W'(left) + DIFF_W'(right);

  assign in_tready      = !fifo_full;
  assign push           = in_tvalid && in_tready;
  assign push_data.mono = stereo_mode ? sum[DIFF_W-1:1] : left;
  assign push_data.last = in_tlast;

endmodule

// File: rtl/core/lrd_fifo.sv
// Short queue of mono frames between the front end and the back end.
// Depends on lrd_pkg.
module lrd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lrd_pkg::frame_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lrd_pkg::frame_t head
);
  import lrd_pkg::*;

  frame_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic               do_pop;

  assign full      = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/lrd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on lrd_pkg; the upper dividend bits must already be below the divisor.
module lrd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lrd_pkg::div_req_t req,
  output lrd_pkg::div_rsp_t rsp
);
  import lrd_pkg::*;

  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  acc_r, acc_nxt;
  logic [RATE_W-1:0] divisor_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, acc_r[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign ge    = (trial >= {1'b0, divisor_r});

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      rem_nxt = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      acc_nxt = {acc_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      rem_nxt  = req.dividend[DVD_W-1:QUO_W];
      acc_nxt  = req.dividend[QUO_W-1:0];
      cnt_nxt  = QCNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    if (!busy_r && req.start) begin
      divisor_r <= req.divisor;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = acc_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/core/lrd_back.sv
// Back end: phase tracking, output counts, interpolation and result register.
// Depends on lrd_pkg; uses lrd_div through its request and response structs.
module lrd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrd_pkg::cfg_t         cfg,
  input  logic                  fifo_not_empty,
  input  lrd_pkg::frame_t       fifo_head,
  output logic                  fifo_pop,
  output lrd_pkg::div_req_t     div_req,
  input  lrd_pkg::div_rsp_t     div_rsp,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // pcm_out[23:0]
  output logic                  out_tlast,  // out_last
  output logic                  out_tuser   // dropped
);
  import lrd_pkg::*;

  back_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic [PHASE_W-1:0]            phase_r, phase_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic                          last_r, last_nxt;
  logic [PHASE_W-1:0]            p0_r, p0_nxt;
  logic [PHASE_W-1:0]            pw_r, pw_nxt;
  logic [PHASE_W-1:0]            k1_r, k1_nxt;
  logic [PHASE_W-1:0]            k2_r, k2_nxt;
  logic                          drop_r, drop_nxt;
  logic [EMIT_W-1:0]             emit_r, emit_nxt;
  logic [EMIT_W-1:0]             idx_r, idx_nxt;
  logic [PHASE_W-1:0]            ph_r, ph_nxt;
  logic signed [DIFF_W-1:0]      diff_r, diff_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic                          neg_r, neg_nxt;
  logic                          ovalid_r, ovalid_nxt;
  logic [SAMPLE_BITS-1:0]        odata_r, odata_nxt;
  logic                          olast_r, olast_nxt;
  logic                          odrop_r, odrop_nxt;

  logic                          rates_ok;
  logic                          pw_ge_out;
  logic [PHASE_W:0]              span_num;
  logic [2*PHASE_W-1:0]          kmul;
  logic signed [PROD_W-1:0]      imul;
  logic [PHASE_W:0]              total;
  logic [PROD_W-1:0]             mag;
  logic signed [QUO_W:0]         qadj;
  logic signed [QUO_W:0]         val;
  logic [EMIT_W-1:0]             idx_inc;

  assign rates_ok  = (cfg.in_rate != '0) && (cfg.out_rate != '0);
  assign pw_ge_out = (pw_r >= PHASE_W'(cfg.out_rate));
  // Outputs left in the interval: ceil((out_rate - pw) / in_rate), pw below out_rate.
  assign span_num  = (PHASE_W+1)'(cfg.out_rate) - (PHASE_W+1)'(pw_r)
                   + (PHASE_W+1)'(cfg.in_rate) - (PHASE_W+1)'(1);
  assign kmul      = k1_r * cfg.in_rate;
  assign imul      = diff_r * $signed({1'b0, ph_r[RATE_W-1:0]});
  assign total     = (PHASE_W+1)'(k1_r) + (PHASE_W+1)'(k2_r);
  assign mag       = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  // Floor division of a negative product rounds the magnitude up.
  assign qadj      = neg_r ? -$signed({1'b0, div_rsp.quot} + (QUO_W+1)'(div_rsp.rem != '0))
                           : $signed({1'b0, div_rsp.quot});
  assign val       = (QUO_W+1)'(prev_r) + qadj;
  assign idx_inc   = idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    phase_nxt     = phase_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    p0_nxt        = p0_r;
    pw_nxt        = pw_r;
    k1_nxt        = k1_r;
    k2_nxt        = k2_r;
    drop_nxt      = drop_r;
    emit_nxt      = emit_r;
    idx_nxt       = idx_r;
    ph_nxt        = ph_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    ovalid_nxt    = ovalid_r;
    odata_nxt     = odata_r;
    olast_nxt     = olast_r;
    odrop_nxt     = odrop_r;
    fifo_pop      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(span_num);
    div_req.divisor  = cfg.in_rate;

    case (state_r)
      ST_IDLE: begin
        if (fifo_not_empty) begin
          fifo_pop  = 1'b1;
          cur_nxt   = fifo_head.mono;
          last_nxt  = fifo_head.last;
          p0_nxt    = phase_r;
          pw_nxt    = phase_r;
          k1_nxt    = '0;
          k2_nxt    = '0;
          state_nxt = (rates_ok && have_prev_r) ? ST_K1_START : ST_K2_START;
        end
      end
      ST_K1_START: begin
        if (pw_ge_out) begin
          pw_nxt    = pw_r - PHASE_W'(cfg.out_rate);
          state_nxt = ST_K2_START;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_K1_WAIT;
        end
      end
      ST_K1_WAIT: begin
        if (div_rsp.done) begin
          k1_nxt    = div_rsp.quot[PHASE_W-1:0];
          state_nxt = ST_K1_MUL;
        end
      end
      ST_K1_MUL: begin
        prod_nxt  = $signed(PROD_W'(kmul));
        state_nxt = ST_K1_ADD;
      end
      ST_K1_ADD: begin
        // Phase lands below in_rate, so the low bits hold it exactly.
        pw_nxt    = PHASE_W'((2*PHASE_W)'(pw_r) + prod_r[2*PHASE_W-1:0]
                    - (2*PHASE_W)'(cfg.out_rate));
        state_nxt = ST_K2_START;
      end
      ST_K2_START: begin
        if (!(rates_ok && last_r) || pw_ge_out) begin
          state_nxt = ST_PLAN;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_K2_WAIT;
        end
      end
      ST_K2_WAIT: begin
        if (div_rsp.done) begin
          k2_nxt    = div_rsp.quot[PHASE_W-1:0];
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        drop_nxt  = (total > (PHASE_W+1)'(MAX_OUTPUTS));
        emit_nxt  = drop_nxt ? EMIT_W'(MAX_OUTPUTS) : total[EMIT_W-1:0];
        idx_nxt   = '0;
        ph_nxt    = p0_r;
        state_nxt = (emit_nxt == '0) ? ST_FINISH : ST_OUT_START;
      end
      ST_OUT_START: begin
        if (PHASE_W'(idx_r) < k1_r) begin
          diff_nxt  = DIFF_W'(cur_r) - DIFF_W'(prev_r);
          state_nxt = ST_OUT_MUL;
        end else begin
          odata_nxt  = cur_r;
          olast_nxt  = (idx_inc == emit_r);
          odrop_nxt  = drop_r;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_OUT_MUL: begin
        prod_nxt  = imul;
        state_nxt = ST_DIV_START;
      end
      ST_DIV_START: begin
        neg_nxt          = prod_r[PROD_W-1];
        div_req.start    = 1'b1;
        div_req.dividend = mag[DVD_W-1:0];
        div_req.divisor  = cfg.out_rate;
        state_nxt        = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          odata_nxt  = val[SAMPLE_BITS-1:0];
          olast_nxt  = (idx_inc == emit_r);
          odrop_nxt  = drop_r;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          idx_nxt    = idx_inc;
          ph_nxt     = ph_r + PHASE_W'(cfg.in_rate);
          state_nxt  = (idx_inc == emit_r) ? ST_FINISH : ST_OUT_START;
        end
      end
      ST_FINISH: begin
        prev_nxt = cur_r;
        if (last_r) begin
          have_prev_nxt = 1'b0;
          phase_nxt     = '0;
        end else begin
          have_prev_nxt = 1'b1;
          phase_nxt     = rates_ok ? pw_r : '0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      phase_r     <= phase_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    last_r  <= last_nxt;
    p0_r    <= p0_nxt;
    pw_r    <= pw_nxt;
    k1_r    <= k1_nxt;
    k2_r    <= k2_nxt;
    drop_r  <= drop_nxt;
    emit_r  <= emit_nxt;
    idx_r   <= idx_nxt;
    ph_r    <= ph_nxt;
    diff_r  <= diff_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    odrop_r <= odrop_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = odrop_r;

endmodule

// File: rtl/core/linear_resampler_with_downmix.sv
// Top level of the linear resampler with stereo down-mix: config registers and wiring.
// Depends on lrd_pkg, lrd_front, lrd_fifo, lrd_div and lrd_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in_     | slave     | in_tvalid / in_tready  | tdata: left, right; tlast: last frame
//  out_    | master    | out_tvalid/out_tready  | tdata: sample; tlast: last; tuser: drop
//  cfg_    | APB slave | psel+penable, pready=1 | in_rate 0x0, out_rate 0x4, stereo 0x8
//
// Work: a frame costs bookkeeping, more when it ends the stream, plus a divide for
// each interpolated result, while a copied result needs no divide; the shared
// divider (interval counts and each interpolation) sets the cost.
// Reset: synchronous, active low; rates return to 48000, mono mode, empty history.
// Stalls: a two-frame queue lets the input keep accepting while a result waits.
module linear_resampler_with_downmix (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // left_sample[23:0], right_sample[47:24]
  input  logic        in_tlast,   // last_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pcm_out[23:0]
  output logic        out_tlast,  // out_last
  output logic        out_tuser,  // dropped
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lrd_pkg::*;

  logic [RATE_W-1:0]    in_rate_r;
  logic [RATE_W-1:0]    out_rate_r;
  logic                 stereo_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t                 cfg;

  frame_t   push_data;
  frame_t   head;
  logic     push;
  logic     pop;
  logic     fifo_full;
  logic     fifo_not_empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Register file: write on the access phase, read back combinationally.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rate_r  <= IN_RATE_RST;
      out_rate_r <= OUT_RATE_RST;
      stereo_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IN_RATE:     in_rate_r  <= cfg_pwdata[RATE_W-1:0];
        REG_OUT_RATE:    out_rate_r <= cfg_pwdata[RATE_W-1:0];
        REG_STEREO_MODE: stereo_r   <= cfg_pwdata[0];
        default: begin
          // Drop writes to unmapped addresses.
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IN_RATE:     cfg_prdata = 32'(in_rate_r);
      REG_OUT_RATE:    cfg_prdata = 32'(out_rate_r);
      REG_STEREO_MODE: cfg_prdata = 32'(stereo_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.in_rate     = in_rate_r;
  assign cfg.out_rate    = out_rate_r;
  assign cfg.stereo_mode = stereo_r;

  // Front: accept frames and down-mix into the queue.
  lrd_front u_front (
    .stereo_mode (cfg.stereo_mode),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_data   (push_data)
  );

  lrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (fifo_full),
    .not_empty (fifo_not_empty),
    .head      (head)
  );

  // Divider shared by the interval counts and every interpolation.
  lrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Back: advance the phase, count outputs, interpolate and hold each result.
  lrd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .fifo_not_empty (fifo_not_empty),
    .fifo_head      (head),
    .fifo_pop       (pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser)
  );

endmodule

// File: rtl/core/lrd_checker.sv
// Port-level checker of the resampler, bound to the top level.
// Depends on lrd_pkg and linear_resampler_with_downmix_macros.svh.
`include "linear_resampler_with_downmix_macros.svh"

module lrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [3:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);
  import lrd_pkg::*;

  // Hold a stalled result.
  `LRD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // Each result is built anew, so no result follows one in the next cycle.
  `LRD_ASSERT_NEXT(a_out_gap, out_tvalid && out_tready, !out_tvalid)

  // Read back the input rate just written.
  `LRD_ASSERT_NEXT(a_in_rate_rb, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[3:2] == REG_IN_RATE, cfg_paddr[3:2] != REG_IN_RATE || cfg_prdata == {14'd0, $past(cfg_pwdata[17:0])})

  // Read back the stereo flag just written.
  `LRD_ASSERT_NEXT(a_stereo_rb, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[3:2] == REG_STEREO_MODE, cfg_paddr[3:2] != REG_STEREO_MODE || cfg_prdata == {31'd0, $past(cfg_pwdata[0])})

endmodule

bind linear_resampler_with_downmix lrd_checker u_lrd_checker (.*);
